[hdl/record_sort_by_name_key_macros.svh]
`ifndef RECORD_SORT_BY_NAME_KEY_MACROS_SVH
`define RECORD_SORT_BY_NAME_KEY_MACROS_SVH

// Check that cond holds whenever trig holds, at the same edge.
`define RSORT_ASSERT_IMPL(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error(msg);

// Check that cond holds at the edge after trig holds.
`define RSORT_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

[hdl/rsort_pkg.sv]
package rsort_pkg;

	localparam int MAX_RECORDS_DEF = 16;
	localparam int NAME_BYTES      = 8;
	localparam int ID_W            = 20;
	localparam int GRADE_W         = 4;
	localparam int NAME_W          = 64;

	typedef struct packed {
		logic [NAME_W-1:0]  name;
		logic [ID_W-1:0]    id;
		logic [GRADE_W-1:0] grade;
	} rec_t;

	typedef struct packed {
		logic load;
		logic rd_i;
		logic get_i;
		logic scan;
		logic wr_i;
		logic out_rd;
	} cmd_t;

	typedef struct packed {
		logic pass_done;
		logic j_last;
		logic k_last;
	} stat_t;

	// Keep the top NAME_BYTES bytes up to the first zero byte; clear the rest.
	function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] key);
		logic [NAME_W-1:0] res;
		logic              live;
		logic [7:0]        byte_v;
		res  = '0;
		live = 1'b1;
		for (int n = 0; n < 8; n++) begin
			byte_v = key[NAME_W-1-8*n -: 8];
			if (n >= NAME_BYTES || byte_v == 8'h00) begin
				live = 1'b0;
			end
			if (live) begin
				res[NAME_W-1-8*n -: 8] = byte_v;
			end
		end
		return res;
	endfunction

endpackage

[hdl/rsort_ram.sv]
module rsort_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/rsort_ctrl.sv]
module rsort_ctrl import rsort_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  last_record,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_RD_I  = 6'b000010,
		S_GET_I = 6'b000100,
		S_SCAN  = 6'b001000,
		S_WR_I  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start && last_record) begin
					state_d = S_RD_I;
				end
			end
			S_RD_I: begin
				state_d = stat.pass_done ? S_OUT : S_GET_I;
			end
			S_GET_I: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stat.j_last) begin
					state_d = S_WR_I;
				end
			end
			S_WR_I: begin
				state_d = S_RD_I;
			end
			S_OUT: begin
				if (stat.k_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd.load   = start && (state_q == S_IDLE);
		cmd.rd_i   = (state_q == S_RD_I) && !stat.pass_done;
		cmd.get_i  = (state_q == S_GET_I);
		cmd.scan   = (state_q == S_SCAN);
		cmd.wr_i   = (state_q == S_WR_I);
		cmd.out_rd = (state_q == S_OUT);
	end

	assign busy = (state_q != S_IDLE);

endmodule

[hdl/rsort_dp.sv]
`include "record_sort_by_name_key_macros.svh"

module rsort_dp import rsort_pkg::*; #(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic [ID_W-1:0]    student_id,
	input  logic [GRADE_W-1:0] grade,
	input  logic [NAME_W-1:0]  name_key,
	output logic               result_valid,
	output logic [ID_W-1:0]    out_student_id,
	output logic [GRADE_W-1:0] out_grade,
	output logic [NAME_W-1:0]  out_name_key,
	output logic               last_out,
	output logic               overflow
);

	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = $clog2(MAX_RECORDS + 1);

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] k_q;
	rec_t          a_q;
	logic          vld_s1;
	logic          last_s1;
	logic          ovf_s1;

	logic          full;
	logic          swap;
	logic          we;
	logic [AW-1:0] waddr;
	rec_t          wdata;
	logic [AW-1:0] raddr;
	rec_t          rdata;

	assign full           = (cnt_q == CW'(MAX_RECORDS));
	assign swap           = (a_q.name < rdata.name);
	assign stat.pass_done = ((CW'(i_q) + CW'(1)) >= cnt_q);
	assign stat.j_last    = ((CW'(j_q) + CW'(1)) == cnt_q);
	assign stat.k_last    = ((CW'(k_q) + CW'(1)) == cnt_q);

	always_comb begin
		we    = 1'b0;
		waddr = j_q;
		wdata = a_q;
		if (cmd.load && !full) begin
			we         = 1'b1;
			waddr      = cnt_q[AW-1:0];
			wdata.name = norm_name(name_key);
			wdata.id   = student_id;
			wdata.grade = grade;
		end else if (cmd.scan && swap) begin
			we    = 1'b1;
			waddr = j_q;
		end else if (cmd.wr_i) begin
			we    = 1'b1;
			waddr = i_q;
		end
	end

	always_comb begin
		raddr = k_q;
		if (cmd.rd_i) begin
			raddr = i_q;
		end else if (cmd.get_i) begin
			raddr = j_q;
		end else if (cmd.scan) begin
			raddr = j_q + 1'b1;
		end
	end

	rsort_ram #(
		.WIDTH ($bits(rec_t)),
		.DEPTH (MAX_RECORDS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			ovf_s1  <= 1'b0;
		end else begin
			vld_s1 <= cmd.out_rd;
			if (cmd.load) begin
				i_q <= '0;
				k_q <= '0;
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.rd_i) begin
				j_q <= i_q + 1'b1;
			end
			if (cmd.scan && !stat.j_last) begin
				j_q <= j_q + 1'b1;
			end
			if (cmd.wr_i) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.out_rd) begin
				k_q     <= k_q + 1'b1;
				last_s1 <= stat.k_last;
				ovf_s1  <= ovf_q;
				if (stat.k_last) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
			end
		end
	end

	// hold the running candidate for position i
	always_ff @(posedge clk) begin
		if (cmd.get_i || (cmd.scan && swap)) begin
			a_q <= rdata;
		end
	end

	assign result_valid   = vld_s1;
	assign out_student_id = rdata.id;
	assign out_grade      = rdata.grade;
	assign out_name_key   = rdata.name;
	assign last_out       = last_s1;
	assign overflow       = ovf_s1;

	`RSORT_ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CW'(MAX_RECORDS), "count above capacity")
	`RSORT_ASSERT_IMPL(a_j_after_i, clk, arst_n, cmd.scan, j_q > i_q, "scan index not after pass index")
	`RSORT_ASSERT_IMPL(a_last_clears, clk, arst_n, vld_s1 && last_s1, cnt_q == '0 && !ovf_q, "list not cleared after final transfer")

endmodule

[hdl/record_sort_by_name_key.sv]
// Records load one per cycle while busy is low; the transfer with last_record set closes the
// list, and busy then stays high while the list of n records is sorted and sent out. The sort
// runs one name compare per cycle through the single record RAM, each pass i scanning records
// i + 1 to n - 1, and then sends the n results out, one record per cycle, in descending name
// order. Results come on result_valid for one cycle each and cannot be stalled. Records beyond
// capacity are dropped and flagged by overflow on every result of that list. A new list may
// start in the cycle that carries the final result.
module record_sort_by_name_key import rsort_pkg::*; #(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [ID_W-1:0]    student_id,
	input  logic [GRADE_W-1:0] grade,
	input  logic [NAME_W-1:0]  name_key,
	input  logic               last_record,
	output logic               result_valid,
	output logic [ID_W-1:0]    out_student_id,
	output logic [GRADE_W-1:0] out_grade,
	output logic [NAME_W-1:0]  out_name_key,
	output logic               last_out,
	output logic               overflow
);

	cmd_t  cmd;
	stat_t stat;

	rsort_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_record (last_record),
		.stat        (stat),
		.cmd         (cmd),
		.busy        (busy)
	);

	rsort_dp #(
		.MAX_RECORDS (MAX_RECORDS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.student_id     (student_id),
		.grade          (grade),
		.name_key       (name_key),
		.result_valid   (result_valid),
		.out_student_id (out_student_id),
		.out_grade      (out_grade),
		.out_name_key   (out_name_key),
		.last_out       (last_out),
		.overflow       (overflow)
	);

endmodule

[dv/record_sort_by_name_key_tb.sv]
module record_sort_by_name_key_tb import rsort_pkg::*;;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_PRINTS     = 100;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [GRADE_W-1:0] grade;
		logic [NAME_W-1:0]  name;
		logic               last;
		logic               ovf;
	} sorted_rec_t;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               start          = 1'b0;
	logic [ID_W-1:0]    student_id     = '0;
	logic [GRADE_W-1:0] grade          = '0;
	logic [NAME_W-1:0]  name_key       = '0;
	logic               last_record    = 1'b0;
	logic               busy;
	logic               result_valid;
	logic [ID_W-1:0]    out_student_id;
	logic [GRADE_W-1:0] out_grade;
	logic [NAME_W-1:0]  out_name_key;
	logic               last_out;
	logic               overflow;

	rec_t        roster [MAX_RECORDS_DEF];
	int          roster_count   = 0;
	bit          roster_dropped = 1'b0;
	sorted_rec_t sorted_out [$];
	sorted_rec_t next_out;

	bit sender_gaps     = 1'b1;
	int mismatches      = 0;
	int records_sent    = 0;
	int lists_closed    = 0;
	int lists_dropped   = 0;
	int results_checked = 0;
	int stall_cycles    = 0;

	record_sort_by_name_key u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.student_id    (student_id),
		.grade         (grade),
		.name_key      (name_key),
		.last_record   (last_record),
		.result_valid  (result_valid),
		.out_student_id(out_student_id),
		.out_grade     (out_grade),
		.out_name_key  (out_name_key),
		.last_out      (last_out),
		.overflow      (overflow)
	);

	always #5 clk = ~clk;

	function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
		logic [NAME_W-1:0] res;
		logic              live;
		res  = '0;
		live = 1'b1;
		for (int b = 0; b < NAME_BYTES; b++) begin
			if (raw[NAME_W-1-8*b -: 8] == 8'h00) begin
				live = 1'b0;
			end
			if (live) begin
				res[NAME_W-1-8*b -: 8] = raw[NAME_W-1-8*b -: 8];
			end
		end
		return res;
	endfunction

	// Exchange sort, descending by name, then queue the sorted list.
	task automatic close_roster();
		rec_t        tmp;
		sorted_rec_t entry;
		for (int i = 0; i + 1 < roster_count; i++) begin
			for (int j = i + 1; j < roster_count; j++) begin
				if (roster[i].name < roster[j].name) begin
					tmp       = roster[i];
					roster[i] = roster[j];
					roster[j] = tmp;
				end
			end
		end
		for (int k = 0; k < roster_count; k++) begin
			entry.id    = roster[k].id;
			entry.grade = roster[k].grade;
			entry.name  = roster[k].name;
			entry.last  = (k + 1 == roster_count);
			entry.ovf   = roster_dropped;
			sorted_out.push_back(entry);
		end
		lists_closed++;
		if (roster_dropped) begin
			lists_dropped++;
		end
		roster_count   = 0;
		roster_dropped = 1'b0;
	endtask

	task automatic take_record(input logic [ID_W-1:0] id, input logic [GRADE_W-1:0] grd,
		input logic [NAME_W-1:0] key, input logic fin);
		if (roster_count < MAX_RECORDS_DEF) begin
			roster[roster_count].id    = id;
			roster[roster_count].grade = grd;
			roster[roster_count].name  = clean_name(key);
			roster_count++;
		end else begin
			roster_dropped = 1'b1;
		end
		if (fin) begin
			close_roster();
		end
	endtask

	task automatic send_record(input logic [ID_W-1:0] id, input logic [GRADE_W-1:0] grd,
		input logic [NAME_W-1:0] key, input logic fin);
		int gap;
		gap = 0;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
		end
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		student_id  <= id;
		grade       <= grd;
		name_key    <= key;
		last_record <= fin;
		do @(posedge clk); while (busy);
		records_sent++;
		take_record(id, grd, key, fin);
	endtask

	// Hold off the sender until every sorted record has come out.
	task automatic drain_results();
		start <= 1'b0;
		while (sorted_out.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] want,
		input logic [63:0] got);
		mismatches++;
		if (mismatches <= MAX_PRINTS) begin
			$display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
		end
	endtask

	function automatic logic [NAME_W-1:0] random_name(input logic [NAME_W-1:0] prev);
		logic [NAME_W-1:0] key;
		int                len;
		int                pick;
		pick = $urandom_range(0, 9);
		key  = {$urandom(), $urandom()};
		if (pick < 2) begin
			return key;
		end
		if (pick < 4) begin
			return prev;
		end
		len = $urandom_range(0, 8);
		for (int b = 0; b < 8; b++) begin
			if (b < len) begin
				key[NAME_W-1-8*b -: 8] = 8'h41 + 8'($urandom_range(0, 3));
			end else if (pick != 9) begin
				key[NAME_W-1-8*b -: 8] = 8'h00;
			end
		end
		if (pick == 9 && len < 8) begin
			key[NAME_W-1-8*len -: 8] = 8'h00;
		end
		return key;
	endfunction

	task automatic send_random_list(input int len);
		logic [NAME_W-1:0] prev;
		logic [NAME_W-1:0] key;
		prev = {$urandom(), $urandom()};
		for (int n = 0; n < len; n++) begin
			key = random_name(prev);
			send_record(ID_W'($urandom()), GRADE_W'($urandom()), key, n + 1 == len);
			prev = key;
		end
	endtask

	task automatic test_single_record();
		send_record('1, '1, 64'h0, 1'b1);
	endtask

	task automatic test_field_extremes();
		send_record('0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		send_record('1, '1, 64'h0100_0000_0000_0000, 1'b0);
		send_record(20'hA5A5A, 4'h5, 64'h7F80_0102_0304_0506, 1'b1);
	endtask

	task automatic test_equal_names();
		send_record(20'h00001, 4'h1, 64'h4142_0078_797A_0000, 1'b0);
		send_record(20'h00002, 4'h2, 64'h4142_0000_0000_0000, 1'b0);
		send_record(20'h00003, 4'h3, 64'h4142_00FF_0000_0001, 1'b1);
	endtask

	task automatic test_overflow();
		for (int n = 0; n < MAX_RECORDS_DEF; n++) begin
			send_record(ID_W'(n * 4099), GRADE_W'(n), 64'h4100_0000_0000_0000 + (64'(n) << 48),
				1'b0);
		end
		send_record(20'hFFFF0, 4'hE, 64'h5A00_0000_0000_0000, 1'b0);
		send_record(20'hFFFF1, 4'hF, 64'h5B00_0000_0000_0000, 1'b1);
		drain_results();
	endtask

	task automatic test_random_lists();
		int sent_here;
		int len;
		int pick;
		sent_here = 0;
		while (sent_here < 100) begin
			pick = $urandom_range(0, 19);
			if (pick < 15) begin
				len = $urandom_range(1, 8);
			end else if (pick < 19) begin
				len = $urandom_range(9, 16);
			end else begin
				len = $urandom_range(17, 20);
			end
			send_random_list(len);
			sent_here += len;
			if ($urandom_range(0, 7) == 0) begin
				drain_results();
			end
		end
	endtask

	task automatic test_back_to_back();
		sender_gaps = 1'b0;
		send_random_list(MAX_RECORDS_DEF);
		send_random_list(1);
		send_random_list($urandom_range(2, 6));
		send_random_list(1);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			results_checked++;
			if (sorted_out.size() == 0) begin
				report_mismatch("unexpected result name", '0, out_name_key);
			end else begin
				next_out = sorted_out.pop_front();
				if (out_student_id !== next_out.id) begin
					report_mismatch("out_student_id", 64'(next_out.id), 64'(out_student_id));
				end
				if (out_grade !== next_out.grade) begin
					report_mismatch("out_grade", 64'(next_out.grade), 64'(out_grade));
				end
				if (out_name_key !== next_out.name) begin
					report_mismatch("out_name_key", next_out.name, out_name_key);
				end
				if (last_out !== next_out.last) begin
					report_mismatch("last_out", 64'(next_out.last), 64'(last_out));
				end
				if (overflow !== next_out.ovf) begin
					report_mismatch("overflow", 64'(next_out.ovf), 64'(overflow));
				end
			end
		end
	end

	initial begin
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n && ((start && !busy) || result_valid)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_record();
		test_field_extremes();
		test_equal_names();
		test_overflow();
		test_random_lists();
		test_back_to_back();
		start <= 1'b0;
		while (sorted_out.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Loaded %0d records in %0d lists, %0d of them past capacity;",
			records_sent, lists_closed, lists_dropped);
		$display("checked %0d sorted records, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0 && sorted_out.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
